/* src/icdq_pkg.sv */
// Package: operation and status codes for the indexed circular deque.
`timescale 1ns / 1ps
package icdq_pkg;

	// operation codes carried on func
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_GET    = 2'd2;
	localparam logic [1:0] FUNC_SET    = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;

endpackage

/* src/indexed_circular_deque.sv */
// Indexed circular deque: ring store of DEPTH words addressed by logical index.
`timescale 1ns / 1ps
// The deque keeps up to DEPTH words in one synchronous single-port-write
// memory used as a ring; head is the slot of element 0. One item is worked
// at a time and each item gives exactly one result beat. The result beat is
// offered in the same cycle that the block becomes free to take the next
// item. An insert or a remove in the middle shifts n words, where n is the
// number of words on the side that moves: count - index for an insert at or
// past half the count, else index; count - 1 - index for a remove at or past
// half the count, else index. It is at most DEPTH/2. The memory moves one
// word per cycle (read one slot, write it one slot over on the next cycle),
// which sets the cost of the middle cases. While a result beat waits on
// out_stall the block still takes the next item and holds its result until
// the output register frees. Reset needs no clearing pass.
module indexed_circular_deque
	import icdq_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   func,
	input  logic [$clog2(DEPTH+1)-1:0]   index,
	input  logic [WORD_BITS-1:0]         value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [WORD_BITS-1:0]         data,
	output logic [$clog2(DEPTH+1)-1:0]   count,
	output logic [1:0]                   status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RDATA = 3'd1;
	localparam logic [2:0] ST_MOVE  = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	// ring add modulo DEPTH
	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
			input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_q;

	logic [2:0]           state_q;
	logic [AW-1:0]        head_q;
	logic [CW-1:0]        fill_q;
	logic [AW-1:0]        src_q;
	logic [CW-1:0]        left_q;
	logic                 dir_up_q;
	logic                 fin_wr_q;
	logic [AW-1:0]        fin_addr_q;
	logic [WORD_BITS-1:0] fin_data_q;
	logic [WORD_BITS-1:0] res_data_q;
	logic [1:0]           res_status_q;
	logic                 wr_pend_s1;
	logic [AW-1:0]        wr_addr_s1;

	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_data_q;
	logic [CW-1:0]        out_count_q;
	logic [1:0]           out_status_q;

	logic                 accept;
	logic                 out_free;

	// decode of the incoming item
	logic [2:0]           d_state;
	logic [1:0]           d_status;
	logic [AW-1:0]        d_head;
	logic [CW-1:0]        d_fill;
	logic                 d_we;
	logic [AW-1:0]        d_waddr;
	logic [AW-1:0]        d_src;
	logic [CW-1:0]        d_left;
	logic                 d_dir_up;
	logic                 d_fin_wr;
	logic [AW-1:0]        d_fin_addr;
	logic [WORD_BITS-1:0] d_res_data;
	logic [AW-1:0]        phys_idx;
	logic [AW-1:0]        head_dec;
	logic [AW-1:0]        head_inc;
	logic [CW-1:0]        idx_m1;
	logic [CW-1:0]        idx_p1;
	logic [CW-1:0]        fill_m1;
	logic [CW-1:0]        half_fill;

	// memory port
	logic                 we_c;
	logic [AW-1:0]        waddr_c;
	logic [WORD_BITS-1:0] wdata_c;
	logic [AW-1:0]        raddr_c;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign data      = out_data_q;
	assign count     = out_count_q;
	assign status    = out_status_q;

	assign phys_idx  = ring_add(head_q, index[AW-1:0]);
	assign head_dec  = ring_add(head_q, AW'(DEPTH - 1));
	assign head_inc  = ring_add(head_q, AW'(1));
	assign idx_m1    = index - CW'(1);
	assign idx_p1    = index + CW'(1);
	assign fill_m1   = fill_q - CW'(1);
	assign half_fill = fill_q >> 1;

	// plan the item: checks, pointer updates, shift range and final write
	always_comb begin
		d_state    = ST_DONE;
		d_status   = STATUS_OK;
		d_head     = head_q;
		d_fill     = fill_q;
		d_we       = 1'b0;
		d_waddr    = phys_idx;
		d_src      = head_q;
		d_left     = '0;
		d_dir_up   = 1'b1;
		d_fin_wr   = 1'b0;
		d_fin_addr = phys_idx;
		d_res_data = '0;
		unique case (func)
			FUNC_INSERT: begin
				if (index > fill_q) begin
					d_status = STATUS_BAD_INDEX;
				end else if (fill_q == CW'(DEPTH)) begin
					d_status = STATUS_FULL;
				end else if (index == fill_q) begin
					d_fill  = fill_q + CW'(1);
					d_we    = 1'b1;
					d_waddr = ring_add(head_q, fill_q[AW-1:0]);
				end else if (index == '0) begin
					d_head  = head_dec;
					d_fill  = fill_q + CW'(1);
					d_we    = 1'b1;
					d_waddr = head_dec;
				end else if (index >= half_fill) begin
					// open a gap by pushing the back side toward the tail
					d_state    = ST_MOVE;
					d_fill     = fill_q + CW'(1);
					d_src      = ring_add(head_q, fill_m1[AW-1:0]);
					d_left     = fill_q - index;
					d_dir_up   = 1'b0;
					d_fin_wr   = 1'b1;
					d_fin_addr = phys_idx;
				end else begin
					// open a gap by pulling the front side toward the head
					d_state    = ST_MOVE;
					d_head     = head_dec;
					d_fill     = fill_q + CW'(1);
					d_src      = head_q;
					d_left     = index;
					d_dir_up   = 1'b1;
					d_fin_wr   = 1'b1;
					d_fin_addr = ring_add(head_q, idx_m1[AW-1:0]);
				end
			end
			FUNC_REMOVE: begin
				if (index >= fill_q) begin
					d_status = STATUS_BAD_INDEX;
				end else begin
					d_state = ST_RDATA;
					d_fill  = fill_m1;
					if (index == '0) begin
						d_head = head_inc;
					end else if (index == fill_m1) begin
						d_head = head_q;
					end else if (index >= half_fill) begin
						d_src    = ring_add(head_q, idx_p1[AW-1:0]);
						d_left   = fill_m1 - index;
						d_dir_up = 1'b1;
					end else begin
						d_src    = ring_add(head_q, idx_m1[AW-1:0]);
						d_left   = index;
						d_dir_up = 1'b0;
						d_head   = head_inc;
					end
					if (fill_m1 == '0) begin
						d_head = '0;
					end
				end
			end
			FUNC_GET: begin
				if (index >= fill_q) begin
					d_status = STATUS_BAD_INDEX;
				end else begin
					d_state = ST_RDATA;
				end
			end
			FUNC_SET: begin
				if (index >= fill_q) begin
					d_status = STATUS_BAD_INDEX;
				end else begin
					d_we       = 1'b1;
					d_res_data = value;
				end
			end
			default: begin
				d_status = STATUS_BAD_INDEX;
			end
		endcase
	end

	// memory port select: item write, shift write-back, or final insert write
	always_comb begin
		we_c    = 1'b0;
		waddr_c = wr_addr_s1;
		wdata_c = rd_q;
		raddr_c = src_q;
		if (accept) begin
			we_c    = d_we;
			waddr_c = d_waddr;
			wdata_c = value;
			raddr_c = phys_idx;
		end else if (wr_pend_s1) begin
			we_c = 1'b1;
		end else if (state_q == ST_FIN && fin_wr_q) begin
			we_c    = 1'b1;
			waddr_c = fin_addr_q;
			wdata_c = fin_data_q;
		end
	end

	// ring store: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[waddr_c] <= wdata_c;
		end
		rd_q <= mem[raddr_c];
	end

	// hold the plan of the current item
	always_ff @(posedge clk) begin
		if (accept) begin
			fin_addr_q <= d_fin_addr;
			fin_data_q <= value;
		end
	end

	// sequencer: read, shift, final write, hand over the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			fill_q       <= '0;
			src_q        <= '0;
			left_q       <= '0;
			dir_up_q     <= 1'b0;
			fin_wr_q     <= 1'b0;
			res_data_q   <= '0;
			res_status_q <= STATUS_OK;
			wr_pend_s1   <= 1'b0;
			wr_addr_s1   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q      <= d_state;
						head_q       <= d_head;
						fill_q       <= d_fill;
						src_q        <= d_src;
						left_q       <= d_left;
						dir_up_q     <= d_dir_up;
						fin_wr_q     <= d_fin_wr;
						res_data_q   <= d_res_data;
						res_status_q <= d_status;
					end
				end
				ST_RDATA: begin
					res_data_q <= rd_q;
					state_q    <= (left_q != '0) ? ST_MOVE : ST_DONE;
				end
				ST_MOVE: begin
					if (left_q != '0) begin
						// read the next source word; write it one slot back next cycle
						src_q      <= dir_up_q ? ring_add(src_q, AW'(1))
						                       : ring_add(src_q, AW'(DEPTH - 1));
						wr_addr_s1 <= dir_up_q ? ring_add(src_q, AW'(DEPTH - 1))
						                       : ring_add(src_q, AW'(1));
						wr_pend_s1 <= 1'b1;
						left_q     <= left_q - CW'(1);
					end else begin
						wr_pend_s1 <= 1'b0;
						state_q    <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register: load a finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q   <= res_data_q;
			out_count_q  <= fill_q;
			out_status_q <= res_status_q;
		end
	end

endmodule
